FILE: rtl/core/mprc_pkg.sv
// ----------------------------------------------------------------------------
// mprc_pkg: shared types and constants of the motor power ramp
// Command and result records, configuration bundle, clamp helpers.
// ----------------------------------------------------------------------------
package mprc_pkg;

    // Input command codes
    localparam logic [2:0] MODE_SET_NOW   = 3'd0;
    localparam logic [2:0] MODE_SMOOTH    = 3'd1;
    localparam logic [2:0] MODE_STEP      = 3'd2;
    localparam logic [2:0] MODE_SET_ACCEL = 3'd3;
    localparam logic [2:0] MODE_SET_DECEL = 3'd4;

    // Channel selector code that picks every motor
    localparam logic [1:0] SEL_ALL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_UPDATE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_COAST_HOLD    = 2'd1;
    localparam logic [1:0] CFG_COAST_THRESH  = 2'd2;

    // Reset values
    localparam logic [15:0] RESET_UPDATE_PERIOD = 16'd20;
    localparam logic [15:0] RESET_COAST_HOLD    = 16'd1000;
    localparam logic [6:0]  RESET_COAST_THRESH  = 7'd10;
    localparam logic [6:0]  RESET_RATE          = 7'd10;

    // Power and rate limits
    localparam logic signed [7:0] POWER_MAX   = 8'sd100;
    localparam logic signed [7:0] POWER_MIN   = -8'sd100;
    localparam logic signed [7:0] DRIVE_FLOAT = -8'sd128;
    localparam logic [7:0]        RATE_MAX    = 8'd100;
    localparam logic [6:0]        RATE_MIN    = 7'd1;

    // Large-drop coast detection
    localparam logic [7:0] COAST_MIN_MAG = 8'd30;
    localparam logic [7:0] COAST_DROP    = 8'd20;

    // Work kinds handed from the front to the back
    typedef enum logic [2:0] {
        OP_SET_NOW,
        OP_SMOOTH,
        OP_STEP,
        OP_STEP_EARLY,
        OP_RATE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        sel;
        logic signed [7:0] power;
        logic              acc_we;
        logic [6:0]        acc_val;
        logic              dec_we;
        logic [6:0]        dec_val;
        logic [31:0]       now;
    } cmd_t;

    typedef struct packed {
        logic              write_valid;
        logic              motor_index;
        logic signed [7:0] drive_value;
        logic              ramping;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [15:0] update_period;
        logic [15:0] coast_hold;
        logic [6:0]  coast_threshold;
    } cfg_t;

    function automatic logic [7:0] abs8(input logic signed [7:0] v);
        logic [7:0] m;
        m = v[7] ? 8'(-v) : 8'(v);
        return m;
    endfunction

    function automatic logic signed [7:0] clamp_power(input logic signed [7:0] v);
        logic signed [7:0] r;
        if (v > POWER_MAX) r = POWER_MAX;
        else if (v < POWER_MIN) r = POWER_MIN;
        else r = v;
        return r;
    endfunction

    function automatic logic [6:0] clamp_rate(input logic [7:0] v);
        logic [6:0] r;
        if (v == 8'd0) r = RATE_MIN;
        else if (v > RATE_MAX) r = RATE_MAX[6:0];
        else r = v[6:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/mprc_fifo.sv
// ----------------------------------------------------------------------------
// mprc_fifo: small register queue
// Generic first-in first-out store with push/pop and full/empty flags.
// ----------------------------------------------------------------------------
module mprc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/mprc_front.sv
// ----------------------------------------------------------------------------
// mprc_front: command intake and classification
// Clamps requests, resolves rate updates and decides early versus taken steps.
// ----------------------------------------------------------------------------
module mprc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         mode,
    input  logic [1:0]         channel_select,
    input  logic signed [7:0]  power_request,
    input  logic [7:0]         accel_request,
    input  logic [7:0]         decel_request,
    input  logic [31:0]        now_ms,
    input  mprc_pkg::cfg_t     cfg,
    input  logic               cmd_full,
    output logic               cmd_push,
    output mprc_pkg::cmd_t     cmd
);

    logic [31:0] last_step_reg, last_step_next;
    logic [31:0] elapsed;
    logic        accept;
    logic        taken;
    logic        has_work;

    assign full    = cmd_full;
    assign accept  = push && !cmd_full;
    assign elapsed = now_ms - last_step_reg;
    assign taken   = (elapsed >= {16'b0, cfg.update_period});

    always_comb
    begin
        cmd.op      = mprc_pkg::OP_RATE;
        cmd.sel     = channel_select;
        cmd.power   = mprc_pkg::clamp_power(power_request);
        cmd.acc_we  = 1'b0;
        cmd.acc_val = mprc_pkg::clamp_rate(accel_request);
        cmd.dec_we  = 1'b0;
        cmd.dec_val = mprc_pkg::clamp_rate(decel_request);
        cmd.now     = now_ms;
        has_work    = 1'b1;
        unique case (mode)
            mprc_pkg::MODE_SET_NOW:
            begin
                cmd.op = mprc_pkg::OP_SET_NOW;
            end
            mprc_pkg::MODE_SMOOTH:
            begin
                cmd.op     = mprc_pkg::OP_SMOOTH;
                cmd.acc_we = (accel_request != 8'd0);
                cmd.dec_we = (decel_request != 8'd0) || (accel_request != 8'd0);
                // zero decel follows the new accel rate
                if (decel_request == 8'd0)
                begin
                    cmd.dec_val = mprc_pkg::clamp_rate(accel_request);
                end
            end
            mprc_pkg::MODE_STEP:
            begin
                cmd.op = taken ? mprc_pkg::OP_STEP : mprc_pkg::OP_STEP_EARLY;
            end
            mprc_pkg::MODE_SET_ACCEL:
            begin
                cmd.acc_we = 1'b1;
            end
            mprc_pkg::MODE_SET_DECEL:
            begin
                cmd.dec_we = 1'b1;
            end
            default:
            begin
                has_work = 1'b0;
            end
        endcase
    end

    assign cmd_push = accept && has_work;

    // Track the step clock here so the back never waits on it.
    always_comb
    begin
        last_step_next = last_step_reg;
        if (accept && (mode == mprc_pkg::MODE_STEP) && taken)
        begin
            last_step_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_step_reg <= '0;
        end
        else
        begin
            last_step_reg <= last_step_next;
        end
    end

endmodule

FILE: rtl/core/mprc_back.sv
// ----------------------------------------------------------------------------
// mprc_back: per-channel execution
// Walks channels one per cycle unless stalled; updates state, emits results.
// ----------------------------------------------------------------------------
module mprc_back #(
    parameter int CHANNELS = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mprc_pkg::cfg_t cfg,
    input  mprc_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output mprc_pkg::res_t res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [7:0] cur_reg   [CHANNELS];
    logic signed [7:0] cur_next  [CHANNELS];
    logic signed [7:0] tgt_reg   [CHANNELS];
    logic signed [7:0] tgt_next  [CHANNELS];
    logic              coast_reg [CHANNELS];
    logic              coast_next[CHANNELS];
    logic [31:0]       start_reg [CHANNELS];
    logic [31:0]       start_next[CHANNELS];

    logic [6:0]        accel_reg, accel_next;
    logic [6:0]        decel_reg, decel_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              ramp_acc_reg, ramp_acc_next;
    logic              emitted_reg, emitted_next;

    logic [CHANNELS-1:0] sel_v, hold_v, ramp_v, drop_v, w_v, exp_v;
    logic              later_w, ramp_rest, any_diff;

    logic signed [7:0] cur_c, tgt_c;
    logic signed [8:0] cur9, tgt9, up9, dn9;
    logic              grow, to_float, w_c, last_ch, single, done, go, emit;
    logic [6:0]        rate;
    logic signed [7:0] stepped, step_drive, step_cur, drive_c;

    // Classify every channel against the current command.
    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
        begin
            sel_v[j]  = (cmd.sel == mprc_pkg::SEL_ALL) ||
                        ((32'(cmd.sel) < 32'(CHANNELS)) && (32'(cmd.sel) == 32'(j)));
            exp_v[j]  = ((cmd.now - start_reg[j]) >= {16'b0, cfg.coast_hold});
            hold_v[j] = coast_reg[j] && !exp_v[j];
            ramp_v[j] = hold_v[j] || (cur_reg[j] != tgt_reg[j]);
            drop_v[j] = (mprc_pkg::abs8(cur_reg[j]) > mprc_pkg::COAST_MIN_MAG) &&
                        (mprc_pkg::abs8(cmd.power) <
                         (mprc_pkg::abs8(cur_reg[j]) - mprc_pkg::COAST_DROP));
            unique case (cmd.op)
                mprc_pkg::OP_SET_NOW:    w_v[j] = sel_v[j];
                mprc_pkg::OP_SMOOTH:     w_v[j] = sel_v[j] && drop_v[j];
                mprc_pkg::OP_STEP:       w_v[j] = !hold_v[j] && (cur_reg[j] != tgt_reg[j]);
                default:                 w_v[j] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        later_w   = 1'b0;
        ramp_rest = 1'b0;
        any_diff  = 1'b0;
        for (int j = 0; j < CHANNELS; j++)
        begin
            if (32'(j) > 32'(ch_reg))
            begin
                later_w = later_w | w_v[j];
            end
            if (32'(j) >= 32'(ch_reg))
            begin
                ramp_rest = ramp_rest | ramp_v[j];
            end
            any_diff = any_diff | (cur_reg[j] != tgt_reg[j]);
        end
    end

    // One ramp step on the channel in hand.
    assign cur_c = cur_reg[ch_reg];
    assign tgt_c = tgt_reg[ch_reg];
    assign w_c   = w_v[ch_reg];
    assign cur9  = {cur_c[7], cur_c};
    assign tgt9  = {tgt_c[7], tgt_c};
    assign grow  = (mprc_pkg::abs8(tgt_c) > mprc_pkg::abs8(cur_c));
    assign rate  = grow ? accel_reg : decel_reg;
    assign up9   = cur9 + $signed({2'b00, rate});
    assign dn9   = cur9 - $signed({2'b00, rate});

    always_comb
    begin
        if (cur_c < tgt_c)
        begin
            stepped = (up9 > tgt9) ? tgt_c : $signed(up9[7:0]);
        end
        else
        begin
            stepped = (dn9 < tgt9) ? tgt_c : $signed(dn9[7:0]);
        end
        to_float = (mprc_pkg::abs8(tgt_c) < mprc_pkg::abs8(cur_c)) &&
                   (mprc_pkg::abs8(stepped) < {1'b0, cfg.coast_threshold}) &&
                   (tgt_c == 8'sd0);
        step_drive = to_float ? mprc_pkg::DRIVE_FLOAT : stepped;
        step_cur   = to_float ? 8'sd0 : stepped;
    end

    assign last_ch = (ch_reg == CH_W'(CHANNELS - 1));
    assign single  = (cmd.op == mprc_pkg::OP_STEP_EARLY) || (cmd.op == mprc_pkg::OP_RATE);
    assign done    = single || last_ch;
    assign go      = cmd_valid && !res_full;

    // Result for this cycle.
    always_comb
    begin
        emit        = 1'b0;
        drive_c     = 8'sd0;
        res.ramping = 1'b0;
        unique case (cmd.op)
            mprc_pkg::OP_SET_NOW:
            begin
                emit    = w_c;
                drive_c = cmd.power;
            end
            mprc_pkg::OP_SMOOTH:
            begin
                emit    = w_c;
                drive_c = mprc_pkg::DRIVE_FLOAT;
            end
            mprc_pkg::OP_STEP:
            begin
                // a step with no writes still reports once
                emit        = w_c || (last_ch && !emitted_reg);
                drive_c     = step_drive;
                res.ramping = ramp_acc_reg | ramp_rest;
            end
            mprc_pkg::OP_STEP_EARLY:
            begin
                emit        = 1'b1;
                res.ramping = any_diff;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        res.write_valid = w_c;
        res.motor_index = w_c ? ch_reg[0] : 1'b0;
        res.drive_value = w_c ? drive_c : 8'sd0;
        res.last        = w_c ? !later_w : 1'b1;
    end

    assign res_push = go && emit;
    assign cmd_pop  = go && done;

    // State updates for the channel in hand.
    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
        begin
            cur_next[j]   = cur_reg[j];
            tgt_next[j]   = tgt_reg[j];
            coast_next[j] = coast_reg[j];
            start_next[j] = start_reg[j];
            if (go && (32'(ch_reg) == 32'(j)))
            begin
                unique case (cmd.op)
                    mprc_pkg::OP_SET_NOW:
                    begin
                        if (sel_v[j])
                        begin
                            cur_next[j] = cmd.power;
                            tgt_next[j] = cmd.power;
                        end
                    end
                    mprc_pkg::OP_SMOOTH:
                    begin
                        if (sel_v[j])
                        begin
                            tgt_next[j] = cmd.power;
                            if (drop_v[j])
                            begin
                                coast_next[j] = 1'b1;
                                start_next[j] = cmd.now;
                            end
                        end
                    end
                    mprc_pkg::OP_STEP:
                    begin
                        if (coast_reg[j] && exp_v[j])
                        begin
                            coast_next[j] = 1'b0;
                        end
                        if (w_v[j])
                        begin
                            cur_next[j] = step_cur;
                        end
                    end
                    default:
                    begin
                        cur_next[j] = cur_reg[j];
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        accel_next    = accel_reg;
        decel_next    = decel_reg;
        ch_next       = ch_reg;
        ramp_acc_next = ramp_acc_reg;
        emitted_next  = emitted_reg;
        if (go)
        begin
            if (done)
            begin
                ch_next       = '0;
                ramp_acc_next = 1'b0;
                emitted_next  = 1'b0;
                if ((cmd.op == mprc_pkg::OP_SMOOTH) || (cmd.op == mprc_pkg::OP_RATE))
                begin
                    if (cmd.acc_we) accel_next = cmd.acc_val;
                    if (cmd.dec_we) decel_next = cmd.dec_val;
                end
            end
            else
            begin
                ch_next       = ch_reg + 1'b1;
                ramp_acc_next = ramp_acc_reg | ramp_v[ch_reg];
                emitted_next  = emitted_reg | emit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < CHANNELS; j++)
            begin
                cur_reg[j]   <= '0;
                tgt_reg[j]   <= '0;
                coast_reg[j] <= 1'b0;
                start_reg[j] <= '0;
            end
            accel_reg    <= mprc_pkg::RESET_RATE;
            decel_reg    <= mprc_pkg::RESET_RATE;
            ch_reg       <= '0;
            ramp_acc_reg <= 1'b0;
            emitted_reg  <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < CHANNELS; j++)
            begin
                cur_reg[j]   <= cur_next[j];
                tgt_reg[j]   <= tgt_next[j];
                coast_reg[j] <= coast_next[j];
                start_reg[j] <= start_next[j];
            end
            accel_reg    <= accel_next;
            decel_reg    <= decel_next;
            ch_reg       <= ch_next;
            ramp_acc_reg <= ramp_acc_next;
            emitted_reg  <= emitted_next;
        end
    end

endmodule

FILE: rtl/core/motor_power_ramp_with_coast.sv
// ----------------------------------------------------------------------------
// motor_power_ramp_with_coast: motor power ramp generator with timed coast
// Multi-channel slew-rate limiter; commands in, motor drive writes out.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port (push/full) and results leave
// through another (empty/pop). The front clamps and classifies each command
// in the cycle it is taken and drops it into a short command queue; the
// back then works through the motors one per cycle while the result queue
// has room, so set-now, smooth-target and update-step commands visit every
// motor, while rate commands and early steps do not walk the motors. The
// back takes no new command until it is through with the last one. The
// first result of a command reaches the result port through the command
// queue register and then the result queue register, when the back is free
// and the result queue has room.
// A command yields zero to CHANNELS results, motor 0 first; last marks the
// final one. Rate commands yield none; an update step always yields at
// least one. Write configuration registers only while no command is in
// flight; the cfg channel is always ready.
// ----------------------------------------------------------------------------
module motor_power_ramp_with_coast #(
    parameter int CHANNELS  = 2,
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,

    // command queue side
    input  logic              push,
    output logic              full,
    input  logic [2:0]        mode,
    input  logic [1:0]        channel_select,
    input  logic signed [7:0] power_request,
    input  logic [7:0]        accel_request,
    input  logic [7:0]        decel_request,
    input  logic [31:0]       now_ms,

    // result queue side
    output logic              empty,
    input  logic              pop,
    output logic              write_valid,
    output logic              motor_index,
    output logic signed [7:0] drive_value,
    output logic              ramping,
    output logic              last,

    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int CMD_W = $bits(mprc_pkg::cmd_t);
    localparam int RES_W = $bits(mprc_pkg::res_t);

    mprc_pkg::cfg_t  cfg_reg, cfg_next;
    mprc_pkg::cmd_t  cmd_in, cmd_out;
    mprc_pkg::res_t  res_in, res_out;
    logic [CMD_W-1:0] cmd_rd;
    logic [RES_W-1:0] res_rd;
    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic             res_push, res_full;
    logic             cfg_xfer;

    // Configuration registers: always ready, one transfer per cycle.
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_xfer)
        begin
            unique case (cfg_index)
                mprc_pkg::CFG_UPDATE_PERIOD: cfg_next.update_period   = cfg_data;
                mprc_pkg::CFG_COAST_HOLD:    cfg_next.coast_hold      = cfg_data;
                mprc_pkg::CFG_COAST_THRESH:  cfg_next.coast_threshold = cfg_data[6:0];
                default:                     cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_period   <= mprc_pkg::RESET_UPDATE_PERIOD;
            cfg_reg.coast_hold      <= mprc_pkg::RESET_COAST_HOLD;
            cfg_reg.coast_threshold <= mprc_pkg::RESET_COAST_THRESH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: take, clamp and classify commands.
    mprc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .channel_select (channel_select),
        .power_request  (power_request),
        .accel_request  (accel_request),
        .decel_request  (decel_request),
        .now_ms         (now_ms),
        .cfg            (cfg_reg),
        .cmd_full       (cmd_full),
        .cmd_push       (cmd_push),
        .cmd            (cmd_in)
    );

    // Decouple front and back so each stalls on its own.
    mprc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    assign cmd_out = mprc_pkg::cmd_t'(cmd_rd);

    // Back: walk the motors and produce drive writes.
    mprc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd_out),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Hold finished results until the consumer pops them.
    mprc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign res_out     = mprc_pkg::res_t'(res_rd);
    assign write_valid = res_out.write_valid;
    assign motor_index = res_out.motor_index;
    assign drive_value = res_out.drive_value;
    assign ramping     = res_out.ramping;
    assign last        = res_out.last;

endmodule
